// ===== rtl/core/vn_pkg.sv =====
// shared types and constants for the vector normalizer
package vn_pkg;

    localparam int unsigned CompW   = 32;
    localparam int unsigned Lanes   = 3;
    localparam int unsigned FracW   = 30;
    localparam int unsigned SqrtSt  = 32;
    localparam int unsigned DivSt   = 32;
    localparam int unsigned QDepth  = 4;

    localparam logic [CompW-1:0] PosMax = 32'h7FFF_FFFF;
    localparam logic [CompW-1:0] NegMax = 32'h8000_0000;

    typedef struct packed {
        logic [Lanes-1:0][CompW-1:0] mag;
        logic [Lanes-1:0]            neg;
    } vec_t;

    typedef struct packed {
        vec_t             vec;
        logic [CompW-1:0] len;
    } item_t;

endpackage

// ===== rtl/core/vn_front.sv =====
// front pipeline: magnitudes, sum of squares and floor square root
module vn_front
    import vn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [CompW-1:0] vec_x,
    input  logic [CompW-1:0] vec_y,
    input  logic [CompW-1:0] vec_z,
    output logic             out_valid,
    input  logic             out_ready,
    output item_t            out_item
);

    localparam int unsigned NS = SqrtSt + 3;

    logic [NS-1:0]    vld_reg;
    logic             en;
    vec_t             in_vec;
    vec_t             pl0_reg;
    vec_t             pl1_reg;
    vec_t             pl2_reg;
    logic [63:0]      sq_reg [0:Lanes-1];
    logic [63:0]      sum_reg;
    vec_t             spl_reg  [0:SqrtSt-1];
    logic [63:0]      rad_reg  [0:SqrtSt-1];
    logic [35:0]      rem_reg  [0:SqrtSt-1];
    logic [CompW-1:0] root_reg [0:SqrtSt-1];
    logic [63:0]      rad_next  [0:SqrtSt-1];
    logic [35:0]      rem_next  [0:SqrtSt-1];
    logic [CompW-1:0] root_next [0:SqrtSt-1];
    vec_t             spl_next  [0:SqrtSt-1];

    assign en       = !vld_reg[NS-1] || out_ready;
    assign in_ready = en;

    always_comb
    begin
        logic [CompW-1:0] raw [0:Lanes-1];
        raw[0] = vec_x;
        raw[1] = vec_y;
        raw[2] = vec_z;
        for (int i = 0; i < Lanes; i++)
        begin
            in_vec.neg[i] = raw[i][CompW-1];
            in_vec.mag[i] = raw[i][CompW-1] ? (~raw[i] + 32'd1) : raw[i];
        end
    end

    // one root bit per stage
    always_comb
    begin
        logic [63:0]      rad_in;
        logic [35:0]      rem_in;
        logic [CompW-1:0] root_in;
        logic [35:0]      t;
        logic [35:0]      trial;
        for (int k = 0; k < SqrtSt; k++)
        begin
            if (k == 0)
            begin
                rad_in      = sum_reg;
                rem_in      = '0;
                root_in     = '0;
                spl_next[k] = pl2_reg;
            end
            else
            begin
                rad_in      = rad_reg[k-1];
                rem_in      = rem_reg[k-1];
                root_in     = root_reg[k-1];
                spl_next[k] = spl_reg[k-1];
            end
            t     = {rem_in[33:0], rad_in[63:62]};
            trial = {2'b00, root_in, 2'b01};
            if (t >= trial)
            begin
                rem_next[k]  = t - trial;
                root_next[k] = {root_in[CompW-2:0], 1'b1};
            end
            else
            begin
                rem_next[k]  = t;
                root_next[k] = {root_in[CompW-2:0], 1'b0};
            end
            rad_next[k] = {rad_in[61:0], 2'b00};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pl0_reg <= in_vec;
            pl1_reg <= pl0_reg;
            for (int i = 0; i < Lanes; i++)
            begin
                sq_reg[i] <= {32'd0, pl0_reg.mag[i]} * {32'd0, pl0_reg.mag[i]};
            end
            pl2_reg <= pl1_reg;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            for (int k = 0; k < SqrtSt; k++)
            begin
                spl_reg[k]  <= spl_next[k];
                rad_reg[k]  <= rad_next[k];
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    assign out_valid    = vld_reg[NS-1];
    assign out_item.vec = spl_reg[SqrtSt-1];
    assign out_item.len = root_reg[SqrtSt-1];

endmodule

// ===== rtl/core/vn_queue.sv =====
// short item queue between the front and back pipelines
module vn_queue
    import vn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  out_valid,
    input  logic  out_ready,
    output item_t out_item
);

    localparam int unsigned AW = $clog2(QDepth);

    item_t         mem [0:QDepth-1];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW:0]   cnt_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (cnt_reg != QDepth[AW:0]);
    assign out_valid = (cnt_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== rtl/core/vn_back.sv =====
// back pipeline: restoring division of each component by the length
module vn_back
    import vn_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  item_t            in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [CompW-1:0] unit_x,
    output logic [CompW-1:0] unit_y,
    output logic [CompW-1:0] unit_z,
    output logic [CompW-1:0] length,
    output logic             zero_length
);

    localparam int unsigned NB = DivSt + 1;

    logic [NB-1:0]    vld_reg;
    logic             en;
    item_t            ipl_reg  [0:DivSt-1];
    logic [CompW-1:0] rem_reg  [0:DivSt-1][0:Lanes-1];
    logic [CompW-1:0] bits_reg [0:DivSt-1][0:Lanes-1];
    logic [CompW-1:0] q_reg    [0:DivSt-1][0:Lanes-1];
    item_t            ipl_next  [0:DivSt-1];
    logic [CompW-1:0] rem_next  [0:DivSt-1][0:Lanes-1];
    logic [CompW-1:0] bits_next [0:DivSt-1][0:Lanes-1];
    logic [CompW-1:0] q_next    [0:DivSt-1][0:Lanes-1];
    logic [CompW-1:0] res_next  [0:Lanes-1];
    logic [CompW-1:0] res_reg   [0:Lanes-1];
    logic [CompW-1:0] len_reg;
    logic             zero_reg;

    assign en       = !vld_reg[NB-1] || out_ready;
    assign in_ready = en;

    // one quotient bit per stage per lane
    always_comb
    begin
        logic [CompW-1:0] rem_in;
        logic [CompW-1:0] bits_in;
        logic [CompW-1:0] q_in;
        logic [CompW:0]   t;
        for (int k = 0; k < DivSt; k++)
        begin
            ipl_next[k] = (k == 0) ? in_item : ipl_reg[k-1];
            for (int i = 0; i < Lanes; i++)
            begin
                if (k == 0)
                begin
                    // dividend is mag shifted up by the fraction width
                    rem_in  = {2'b00, in_item.vec.mag[i][CompW-1:2]};
                    bits_in = {in_item.vec.mag[i][1:0], {FracW{1'b0}}};
                    q_in    = '0;
                end
                else
                begin
                    rem_in  = rem_reg[k-1][i];
                    bits_in = bits_reg[k-1][i];
                    q_in    = q_reg[k-1][i];
                end
                t = {rem_in, bits_in[CompW-1]};
                if (t >= {1'b0, ipl_next[k].len})
                begin
                    rem_next[k][i] = CompW'(t - {1'b0, ipl_next[k].len});
                    q_next[k][i]   = {q_in[CompW-2:0], 1'b1};
                end
                else
                begin
                    rem_next[k][i] = t[CompW-1:0];
                    q_next[k][i]   = {q_in[CompW-2:0], 1'b0};
                end
                bits_next[k][i] = {bits_in[CompW-2:0], 1'b0};
            end
        end
    end

    // saturate and apply sign; a zero length gives a zero result
    always_comb
    begin
        logic [CompW-1:0] q;
        for (int i = 0; i < Lanes; i++)
        begin
            q = q_reg[DivSt-1][i];
            if (ipl_reg[DivSt-1].len == '0)
            begin
                res_next[i] = '0;
            end
            else if (ipl_reg[DivSt-1].vec.neg[i])
            begin
                res_next[i] = (q > NegMax) ? NegMax : (~q + 32'd1);
            end
            else
            begin
                res_next[i] = (q > PosMax) ? PosMax : q;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NB-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DivSt; k++)
            begin
                ipl_reg[k] <= ipl_next[k];
                for (int i = 0; i < Lanes; i++)
                begin
                    rem_reg[k][i]  <= rem_next[k][i];
                    bits_reg[k][i] <= bits_next[k][i];
                    q_reg[k][i]    <= q_next[k][i];
                end
            end
            for (int i = 0; i < Lanes; i++)
            begin
                res_reg[i] <= res_next[i];
            end
            len_reg  <= ipl_reg[DivSt-1].len;
            zero_reg <= (ipl_reg[DivSt-1].len == '0);
        end
    end

    assign out_valid   = vld_reg[NB-1];
    assign unit_x      = res_reg[0];
    assign unit_y      = res_reg[1];
    assign unit_z      = res_reg[2];
    assign length      = len_reg;
    assign zero_length = zero_reg;

endmodule

// ===== rtl/core/vector3_normalize.sv =====
// path: front pipeline, then the item queue, then the back pipeline with its output register
// throughput: one item per cycle unless stalled; a root bit and a quotient bit per stage
// a 4-entry queue lets the front keep accepting items while the output is stalled
// reset: rst_n clears all valid flags and queue pointers, payload registers are not reset
module vector3_normalize
    import vn_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [CompW-1:0] vec_x,
    input  logic signed [CompW-1:0] vec_y,
    input  logic signed [CompW-1:0] vec_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [CompW-1:0] unit_x,
    output logic signed [CompW-1:0] unit_y,
    output logic signed [CompW-1:0] unit_z,
    output logic        [CompW-1:0] length,
    output logic                    zero_length
);

    logic             f_valid;
    logic             f_ready;
    item_t            f_item;
    logic             b_valid;
    logic             b_ready;
    item_t            b_item;
    logic [CompW-1:0] ux;
    logic [CompW-1:0] uy;
    logic [CompW-1:0] uz;

    vn_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    vn_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    vn_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (b_valid),
        .in_ready    (b_ready),
        .in_item     (b_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .unit_x      (ux),
        .unit_y      (uy),
        .unit_z      (uz),
        .length      (length),
        .zero_length (zero_length)
    );

    assign unit_x = ux;
    assign unit_y = uy;
    assign unit_z = uz;

endmodule
